[hw/rtl/assert_macros.svh]
// assertion macros for the rtl modules, included by iie_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk_i, off while rst_ni is low
`define IIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk_i
`define IIE_ASSERT_NEVER(lbl, cond, msg) \
  `IIE_ASSERT(lbl, !(cond), msg)

`endif

[hw/rtl/iie_pkg.sv]
// types, constants and helpers of the expression evaluator
package iie_pkg;

  // width of the internal arithmetic
  localparam int unsigned ValueWidth  = 32;
  // width of the result field on the output channel
  localparam int unsigned ResultWidth = 32;
  // width of the divide step counter
  localparam int unsigned CntWidth    = $clog2(ValueWidth);

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChStar    = 8'd42;
  localparam logic [7:0] ChPlus    = 8'd43;
  localparam logic [7:0] ChMinus   = 8'd45;
  localparam logic [7:0] ChSlash   = 8'd47;
  localparam logic [7:0] ChZero    = 8'd48;
  localparam logic [7:0] ChNine    = 8'd57;

  typedef enum logic [1:0] {
    OpNone = 2'd0,
    OpMul  = 2'd1,
    OpDiv  = 2'd2
  } term_op_e;

  typedef enum logic [2:0] {
    CcSkip  = 3'd0,
    CcDigit = 3'd1,
    CcMul   = 3'd2,
    CcDiv   = 3'd3,
    CcAdd   = 3'd4,
    CcSub   = 3'd5,
    CcEnd   = 3'd6
  } char_class_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       digit_en;
    logic [3:0] digit;
    logic       close_load;
    logic       close_mul;
    logic       div_start;
    logic       div_step;
    logic       div_finish;
    logic       set_op;
    term_op_e   op;
    logic       close_term;
    logic       set_sign;
    logic       sign;
    logic       emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    term_op_e term_op;
  } status_t;

  function automatic char_class_e classify(input logic [7:0] ch);
    char_class_e cls;
    cls = CcSkip;
    if (ch >= ChZero && ch <= ChNine) begin
      cls = CcDigit;
    end else begin
      case (ch)
        ChStar:    cls = CcMul;
        ChSlash:   cls = CcDiv;
        ChPlus:    cls = CcAdd;
        ChMinus:   cls = CcSub;
        ChNewline: cls = CcEnd;
        ChSpace:   cls = CcSkip;
        default:   cls = CcSkip;
      endcase
    end
    return cls;
  endfunction

endpackage

[hw/rtl/iie_if.sv]
// valid/ready channel interfaces of the expression evaluator

interface iie_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface iie_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [iie_pkg::ResultWidth-1:0] result_value;
  logic                                  divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

[hw/rtl/iie_datapath.sv]
// evaluator datapath: accumulators, multiplier, restoring divider, output register
module iie_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iie_pkg::cmd_t                         cmd_i,
  output iie_pkg::status_t                      status_o,
  output logic signed [iie_pkg::ResultWidth-1:0] result_value_o,
  output logic                                  divide_by_zero_o
);

  localparam int unsigned W = iie_pkg::ValueWidth;

  logic [W-1:0]       sum_q, sum_d;
  logic [W-1:0]       term_q, term_d;
  logic [W-1:0]       num_q, num_d;
  logic               sign_q, sign_d;
  iie_pkg::term_op_e  op_q, op_d;
  logic               err_q, err_d;

  // divider state
  logic [W-1:0]       rem_q, rem_d;
  logic [W-1:0]       quo_q, quo_d;
  logic [W-1:0]       dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic               zero_q, zero_d;

  logic signed [iie_pkg::ResultWidth-1:0] res_q, res_d;
  logic                                   dz_q, dz_d;

  logic [W-1:0]   num_x10;
  logic [2*W-1:0] prod_full;
  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     rem_sh;
  logic           rem_ge;
  logic [W:0]     rem_diff;
  logic [W-1:0]   quo_signed;

  assign num_x10   = {num_q[W-4:0], 3'b000} + {num_q[W-2:0], 1'b0};
  assign prod_full = term_q * num_q;
  assign mag_a     = term_q[W-1] ? (W'(0) - term_q) : term_q;
  assign mag_b     = num_q[W-1]  ? (W'(0) - num_q)  : num_q;
  assign rem_sh    = {rem_q, quo_q[W-1]};
  assign rem_ge    = rem_sh >= {1'b0, dvs_q};
  assign rem_diff  = rem_sh - {1'b0, dvs_q};
  assign quo_signed = neg_q ? (W'(0) - quo_q) : quo_q;

  always_comb begin
    sum_d  = sum_q;
    term_d = term_q;
    num_d  = num_q;
    sign_d = sign_q;
    op_d   = op_q;
    err_d  = err_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    res_d  = res_q;
    dz_d   = dz_q;

    if (cmd_i.digit_en) begin
      num_d = num_x10 + W'(cmd_i.digit);
    end
    if (cmd_i.close_load) begin
      term_d = num_q;
      num_d  = '0;
      op_d   = iie_pkg::OpNone;
    end
    if (cmd_i.close_mul) begin
      term_d = prod_full[W-1:0];
      num_d  = '0;
      op_d   = iie_pkg::OpNone;
    end
    if (cmd_i.div_start) begin
      rem_d  = '0;
      quo_d  = mag_a;
      dvs_d  = mag_b;
      neg_d  = term_q[W-1] ^ num_q[W-1];
      zero_d = (num_q == '0);
    end
    if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], rem_ge};
    end
    if (cmd_i.div_finish) begin
      // zero divisor gives a zero quotient and raises the flag
      term_d = zero_q ? '0 : quo_signed;
      err_d  = err_q | zero_q;
      num_d  = '0;
      op_d   = iie_pkg::OpNone;
    end
    if (cmd_i.set_op) begin
      op_d = cmd_i.op;
    end
    if (cmd_i.close_term) begin
      sum_d  = sign_q ? (sum_q - term_q) : (sum_q + term_q);
      term_d = '0;
    end
    if (cmd_i.set_sign) begin
      sign_d = cmd_i.sign;
    end
    if (cmd_i.emit) begin
      res_d  = iie_pkg::ResultWidth'(signed'(sum_q));
      dz_d   = err_q;
      sum_d  = '0;
      term_d = '0;
      num_d  = '0;
      sign_d = 1'b0;
      op_d   = iie_pkg::OpNone;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      term_q <= '0;
      num_q  <= '0;
      sign_q <= 1'b0;
      op_q   <= iie_pkg::OpNone;
      err_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      term_q <= term_d;
      num_q  <= num_d;
      sign_q <= sign_d;
      op_q   <= op_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
    dz_q   <= dz_d;
  end

  assign status_o.term_op = op_q;
  assign result_value_o   = res_q;
  assign divide_by_zero_o = dz_q;

endmodule

[hw/rtl/iie_ctrl.sv]
// evaluator controller: character sequencing, divide counter, output valid
`include "assert_macros.svh"

module iie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_char_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output iie_pkg::cmd_t    cmd_o,
  input  iie_pkg::status_t status_i
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SClose  = 3'd1;
  localparam logic [2:0] SDivRun = 3'd2;
  localparam logic [2:0] SDivEnd = 3'd3;
  localparam logic [2:0] SPost   = 3'd4;
  localparam logic [2:0] SEmit   = 3'd5;

  logic [2:0]                    state_q, state_d;
  iie_pkg::char_class_e          cls_q, cls_d;
  logic [iie_pkg::CntWidth-1:0]  cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  iie_pkg::char_class_e cls_in;
  logic                 accept;
  logic                 slot_free;

  assign cls_in     = iie_pkg::classify(in_char_i);
  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cls_d       = cls_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.digit = in_char_i[3:0];

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (cls_in == iie_pkg::CcDigit) begin
            cmd_o.digit_en = 1'b1;
          end else if (cls_in != iie_pkg::CcSkip) begin
            cls_d   = cls_in;
            state_d = SClose;
          end
        end
      end
      SClose: begin
        case (status_i.term_op)
          iie_pkg::OpMul: begin
            cmd_o.close_mul = 1'b1;
            state_d         = SPost;
          end
          iie_pkg::OpDiv: begin
            cmd_o.div_start = 1'b1;
            cnt_d           = iie_pkg::CntWidth'(iie_pkg::ValueWidth - 1);
            state_d         = SDivRun;
          end
          default: begin
            cmd_o.close_load = 1'b1;
            state_d          = SPost;
          end
        endcase
      end
      SDivRun: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = SDivEnd;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SDivEnd: begin
        cmd_o.div_finish = 1'b1;
        state_d          = SPost;
      end
      SPost: begin
        state_d = SIdle;
        case (cls_q)
          iie_pkg::CcMul: begin
            cmd_o.set_op = 1'b1;
            cmd_o.op     = iie_pkg::OpMul;
          end
          iie_pkg::CcDiv: begin
            cmd_o.set_op = 1'b1;
            cmd_o.op     = iie_pkg::OpDiv;
          end
          iie_pkg::CcAdd: begin
            cmd_o.close_term = 1'b1;
            cmd_o.set_sign   = 1'b1;
            cmd_o.sign       = 1'b0;
          end
          iie_pkg::CcSub: begin
            cmd_o.close_term = 1'b1;
            cmd_o.set_sign   = 1'b1;
            cmd_o.sign       = 1'b1;
          end
          iie_pkg::CcEnd: begin
            cmd_o.close_term = 1'b1;
            state_d          = SEmit;
          end
          default: begin
            state_d = SIdle;
          end
        endcase
      end
      SEmit: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cls_q       <= iie_pkg::CcSkip;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cls_q       <= cls_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a new result never overwrites one that is still waiting
  `IIE_ASSERT_NEVER(a_no_overwrite, cmd_o.emit && out_valid_q && !out_ready_i,
                    "result register overwritten while still pending")
  // the divider runs until its counter ends and then finishes
  `IIE_ASSERT(a_div_seq, state_q == SDivRun |=> state_q == SDivRun || state_q == SDivEnd,
              "divider left its run early")
  // an accepted newline always leads to a close of the pending number
  `IIE_ASSERT(a_nl_closes, accept && in_char_i == iie_pkg::ChNewline |=> state_q == SClose,
              "newline transaction did not start closing")
  // only one way of closing a number at a time
  `IIE_ASSERT(a_one_close,
              $onehot0({cmd_o.close_load, cmd_o.close_mul, cmd_o.div_start, cmd_o.div_finish}),
              "conflicting close commands")

endmodule

[hw/rtl/infix_integer_expression_evaluator.sv]
// top level of the infix integer expression evaluator
//
//  channel   dir  fields                          per transaction
//  char_i    in   char_code[7:0]                  one ascii character
//  result_o  out  result_value[31:0], div-by-zero one result per newline
//
// digits, spaces and unknown characters are taken in the idle state, which stays ready
// + - * / and newline with no pending divide pass through the close and post states, newline also through emit
// a pending divide adds the divide run and finish states: a restoring divider makes one quotient bit a cycle
// a waiting result holds the next newline in the emit state, with input stalled; characters before it are taken
// rst_ni clears the accumulators and control state asynchronously, no result is left pending
module infix_integer_expression_evaluator (
  input logic          clk_i,
  input logic          rst_ni,
  iie_char_if.sink     char_i,
  iie_result_if.source result_o
);

  // command and status between controller and datapath
  iie_pkg::cmd_t    cmd;
  iie_pkg::status_t status;

  // sequencing of each character transaction
  iie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .in_char_i   (char_i.char_code),
    .in_ready_o  (char_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // arithmetic and the result register
  iie_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .result_value_o   (result_o.result_value),
    .divide_by_zero_o (result_o.divide_by_zero)
  );

endmodule
